// ----- hw/rtl/wre_pkg.sv -----
// ----------------------------------------------------------------------------
// wre_pkg: window range and extremes report, shared definitions
// Field widths, default sizes, rank-cell direction and the link structs
// that pass between neighboring cells.
// ----------------------------------------------------------------------------
package wre_pkg;

  localparam int VAL_W  = 8;
  localparam int DIFF_W = 8;
  localparam int POS_W  = 6;
  localparam int RANK_W = 3;

  localparam int DEF_WINDOW  = 10;
  localparam int DEF_SEGMENT = 60;
  localparam int DEF_RANKS   = 5;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [DIFF_W-1:0]       diff_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [RANK_W-1:0]       rank_t;

  localparam value_t HIGH_INIT = value_t'(-128);
  localparam value_t LOW_INIT  = value_t'(127);

  typedef enum logic {
    DIR_HIGH,
    DIR_LOW
  } rank_dir_t;

  // What a rank cell shows its lower neighbor: its slot and whether the
  // incoming reading beats that slot.
  typedef struct packed {
    logic   take;
    value_t value;
  } rank_link_t;

  // Running extremes of one partial window.
  typedef struct packed {
    value_t hi;
    value_t lo;
  } win_link_t;

endpackage

// ----- hw/rtl/wre_if.sv -----
// ----------------------------------------------------------------------------
// wre_in_if / wre_out_if: valid/ready channels of the report block
// One word per handshake; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface wre_in_if;
  import wre_pkg::*;

  logic   valid;
  logic   ready;
  value_t reading;
  logic   period_end;

  modport source (output valid, output reading, output period_end, input ready);
  modport sink   (input valid, input reading, input period_end, output ready);
endinterface

interface wre_out_if;
  import wre_pkg::*;

  logic   valid;
  logic   ready;
  rank_t  rank;
  value_t high_value;
  value_t low_value;
  diff_t  best_difference;
  pos_t   best_window_start;
  logic   last_of_report;

  modport source (output valid, output rank, output high_value, output low_value,
                  output best_difference, output best_window_start,
                  output last_of_report, input ready);
  modport sink   (input valid, input rank, input high_value, input low_value,
                  input best_difference, input best_window_start,
                  input last_of_report, output ready);
endinterface

// ----- hw/rtl/wre_rank_cell.sv -----
// ----------------------------------------------------------------------------
// wre_rank_cell: one compare-insert slot of a ranked list
// Takes the new word if it beats its slot; takes the upper neighbor's
// slot instead if that neighbor also took the word (list shifts down).
// ----------------------------------------------------------------------------
module wre_rank_cell (
  input  logic               clk,
  input  logic               rst,
  input  wre_pkg::rank_dir_t dir,
  input  logic               en,
  input  logic               clr,
  input  wre_pkg::value_t    v,
  input  wre_pkg::rank_link_t prev,
  output wre_pkg::rank_link_t link,
  output wre_pkg::value_t    value_next
);
  import wre_pkg::*;

  value_t value;
  value_t init_value;
  logic   take;

  always_comb begin
    init_value = (dir == DIR_HIGH) ? HIGH_INIT : LOW_INIT;
    take       = (dir == DIR_HIGH) ? (v > value) : (v < value);
    if (take) begin
      value_next = prev.take ? prev.value : v;
    end else begin
      value_next = value;
    end
    link.take  = take;
    link.value = value;
  end

  always_ff @(posedge clk) begin
    if (rst || (en && clr)) begin
      value <= init_value;
    end else if (en) begin
      value <= value_next;
    end
  end

endmodule

// ----- hw/rtl/wre_win_cell.sv -----
// ----------------------------------------------------------------------------
// wre_win_cell: one partial-window extremes accumulator
// Folds the new word into the extremes handed over by its neighbor, so
// the extremes of a window age by one cell per word.
// ----------------------------------------------------------------------------
module wre_win_cell (
  input  logic               clk,
  input  logic               en,
  input  wre_pkg::value_t    v,
  input  wre_pkg::win_link_t seed,
  output wre_pkg::win_link_t acc
);
  import wre_pkg::*;

  win_link_t acc_next;

  always_comb begin
    acc_next.hi = (v > seed.hi) ? v : seed.hi;
    acc_next.lo = (v < seed.lo) ? v : seed.lo;
  end

  // Contents only matter once a whole window of the segment has passed.
  always_ff @(posedge clk) begin
    if (en) begin
      acc <= acc_next;
    end
  end

endmodule

// ----- hw/rtl/window_range_and_extremes_report_top.sv -----
// ----------------------------------------------------------------------------
// window_range_and_extremes_report_top: sliding-window range and top/bottom
// Ranks the highest and lowest readings of a report period and finds the
// window with the widest max-minus-min spread inside each segment.
// ----------------------------------------------------------------------------
//
//   port     dir   word contents
//   -------  ----  ---------------------------------------------------------
//   samples  in    reading (signed 8b), period_end
//   report   out   rank, high_value, low_value, best_difference,
//                  best_window_start, last_of_report (RANKS words per period)
//
// One reading per cycle while ready is high; a reading's effect is complete
// at the edge that accepts it. The window is a chain of WINDOW-1 extremes
// cells plus the current word, so its spread is known in the accept cycle.
// A period_end reading loads a RANKS-deep report shift line and clears the
// ranking, segment position and best window at once; plain readings keep
// flowing while the report drains. A further period_end waits until the
// report line is free (it may enter in the cycle the last report word leaves).
// rst is synchronous: report line empty, rank slots at their extreme values,
// segment position and best window cleared.
// ----------------------------------------------------------------------------
module window_range_and_extremes_report_top #(
  parameter int WINDOW  = wre_pkg::DEF_WINDOW,
  parameter int SEGMENT = wre_pkg::DEF_SEGMENT,
  parameter int RANKS   = wre_pkg::DEF_RANKS
) (
  input logic clk,
  input logic rst,
  wre_in_if.sink    samples,
  wre_out_if.source report
);
  import wre_pkg::*;

  localparam int   RIDX_W = (RANKS > 1) ? $clog2(RANKS) : 1;
  localparam pos_t WIN_M1 = pos_t'(WINDOW - 1);
  localparam pos_t SEG_M1 = pos_t'(SEGMENT - 1);
  localparam logic [RIDX_W-1:0] LAST_RANK = RIDX_W'(RANKS - 1);

  // handshake
  logic accept;
  logic end_accept;
  logic pop;
  logic pop_last;

  // segment / best window
  pos_t  pos;
  pos_t  pos_next;
  diff_t best_diff;
  pos_t  best_start;
  diff_t best_diff_next;
  pos_t  best_start_next;
  logic  win_full;
  value_t win_hi;
  value_t win_lo;
  logic [VAL_W:0] spread;
  diff_t win_diff;

  // cell chains
  win_link_t  win_acc [WINDOW-1];
  rank_link_t top_link [RANKS];
  rank_link_t bot_link [RANKS];
  value_t     top_next [RANKS];
  value_t     bot_next [RANKS];

  // report shift line
  value_t snap_hi [RANKS];
  value_t snap_lo [RANKS];
  diff_t  snap_diff;
  pos_t   snap_start;
  logic   busy;
  logic [RIDX_W-1:0] cnt;

  // --------------------------------------------------------------------------
  // Handshake. Only a period_end word needs the report line.
  // --------------------------------------------------------------------------
  assign pop      = busy && report.ready;
  assign pop_last = pop && (cnt == LAST_RANK);
  assign samples.ready = !busy || !samples.period_end || pop_last;
  assign accept     = samples.valid && samples.ready;
  assign end_accept = accept && samples.period_end;

  // --------------------------------------------------------------------------
  // Window chain: cell i holds extremes of the last i+1 words before this one.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < WINDOW - 1; i++) begin : g_win
    win_link_t seed;
    if (i == 0) begin : g_head
      assign seed = '{hi: samples.reading, lo: samples.reading};
    end else begin : g_body
      assign seed = win_acc[i-1];
    end
    wre_win_cell u_cell (
      .clk  (clk),
      .en   (accept),
      .v    (samples.reading),
      .seed (seed),
      .acc  (win_acc[i])
    );
  end

  always_comb begin
    win_hi = (samples.reading > win_acc[WINDOW-2].hi) ? samples.reading
                                                      : win_acc[WINDOW-2].hi;
    win_lo = (samples.reading < win_acc[WINDOW-2].lo) ? samples.reading
                                                      : win_acc[WINDOW-2].lo;
    spread   = {win_hi[VAL_W-1], win_hi} - {win_lo[VAL_W-1], win_lo};
    win_diff = spread[DIFF_W-1:0];
    // window lies wholly inside the segment once pos reaches WINDOW-1
    win_full = (pos >= WIN_M1);

    best_diff_next  = best_diff;
    best_start_next = best_start;
    if (win_full && (win_diff > best_diff)) begin
      best_diff_next  = win_diff;
      best_start_next = pos - WIN_M1;
    end

    pos_next = (pos == SEG_M1) ? '0 : pos + pos_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst || end_accept) begin
      pos        <= '0;
      best_diff  <= '0;
      best_start <= '0;
    end else if (accept) begin
      pos        <= pos_next;
      best_diff  <= best_diff_next;
      best_start <= best_start_next;
    end
  end

  // --------------------------------------------------------------------------
  // Rank chains: slot 0 is the most extreme.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < RANKS; i++) begin : g_rank
    rank_link_t top_prev;
    rank_link_t bot_prev;
    if (i == 0) begin : g_head
      assign top_prev = '{take: 1'b0, value: '0};
      assign bot_prev = '{take: 1'b0, value: '0};
    end else begin : g_body
      assign top_prev = top_link[i-1];
      assign bot_prev = bot_link[i-1];
    end
    wre_rank_cell u_top (
      .clk        (clk),
      .rst        (rst),
      .dir        (DIR_HIGH),
      .en         (accept),
      .clr        (samples.period_end),
      .v          (samples.reading),
      .prev       (top_prev),
      .link       (top_link[i]),
      .value_next (top_next[i])
    );
    wre_rank_cell u_bot (
      .clk        (clk),
      .rst        (rst),
      .dir        (DIR_LOW),
      .en         (accept),
      .clr        (samples.period_end),
      .v          (samples.reading),
      .prev       (bot_prev),
      .link       (bot_link[i]),
      .value_next (bot_next[i])
    );
  end

  // --------------------------------------------------------------------------
  // Report line: loaded whole on period_end, shifts toward slot 0 per pop.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (end_accept) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (pop_last) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (pop) begin
      cnt <= cnt + RIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (end_accept) begin
      for (int i = 0; i < RANKS; i++) begin
        snap_hi[i] <= top_next[i];
        snap_lo[i] <= bot_next[i];
      end
      snap_diff  <= best_diff_next;
      snap_start <= best_start_next;
    end else if (pop) begin
      for (int i = 0; i < RANKS - 1; i++) begin
        snap_hi[i] <= snap_hi[i+1];
        snap_lo[i] <= snap_lo[i+1];
      end
    end
  end

  assign report.valid             = busy;
  assign report.rank              = RANK_W'(cnt);
  assign report.high_value        = snap_hi[0];
  assign report.low_value         = snap_lo[0];
  assign report.best_difference   = snap_diff;
  assign report.best_window_start = snap_start;
  assign report.last_of_report    = (cnt == LAST_RANK);

endmodule
